// ===== src/assert_macros.svh =====
// Assertion macros for the text console cell writer.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked at every rising clk edge outside reset.
`define TCCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent in this cycle, consequent in the cycle after it.
`define TCCW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define TCCW_ASSERT(label, prop, msg)
`define TCCW_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== src/tccw_pkg.sv =====
// Shared types and codes for the text console cell writer.
// No dependencies.
package tccw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;

  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_SET = 1'b1;

  localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
  localparam logic [7:0] CODE_NEWLINE    = 8'h0A;
  localparam logic [7:0] CODE_RETURN     = 8'h0D;
  localparam logic [7:0] CODE_TAB        = 8'h09;
  localparam logic [7:0] TAB_STEP        = 8'd4;
  localparam logic [7:0] TAB_ALIGN_MASK  = 8'hFC;

  typedef struct packed {
    logic              kind;
    logic [7:0]        char_code;
    logic [7:0]        color;
    logic [COL_W-1:0]  new_col;
    logic [ROW_W-1:0]  new_row;
  } item_t;

  typedef struct packed {
    logic              cell_write;
    logic [ADDR_W-1:0] cell_address;
    logic [7:0]        cell_char;
    logic [6:0]        cell_attr;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } result_t;

endpackage

// ===== src/text_console_cell_writer.sv =====
// Text console cell writer. Each word on the input channel either puts one
// character (kind 0) or moves the cursor (kind 1); every word gives exactly
// one result word carrying an optional cell write and the cursor after it.
// One word per clock is sustained while the consumer keeps out_ready high. A word
// accepted into the input register moves into the result register once the result
// register is free (input register, then result register). The cursor update is
// combinational logic in a loop around the column/row registers, so words follow
// each other with no gaps while results are taken. COLUMNS and ROWS set the
// screen size.
// Depends on tccw_pkg, tccw_in_reg, tccw_cursor, tccw_out_reg, assert_macros.svh.
`include "assert_macros.svh"

module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             kind,
  input  logic [7:0]                       char_code,
  input  logic [7:0]                       color,
  input  logic [tccw_pkg::COL_W-1:0]       new_col,
  input  logic [tccw_pkg::ROW_W-1:0]       new_row,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             cell_write,
  output logic [tccw_pkg::ADDR_W-1:0]      cell_address,
  output logic [7:0]                       cell_char,
  output logic [6:0]                       cell_attr,
  output logic [tccw_pkg::COL_W-1:0]       cursor_col,
  output logic [tccw_pkg::ROW_W-1:0]       cursor_row
);
  import tccw_pkg::*;

  item_t   in_item;
  item_t   held_item;
  result_t next_result;
  result_t out_result;
  logic    drain;
  logic    fire;

  assign in_item.kind      = kind;
  assign in_item.char_code = char_code;
  assign in_item.color     = color;
  assign in_item.new_col   = new_col;
  assign in_item.new_row   = new_row;

  tccw_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .drain     (drain),
    .fire      (fire),
    .held_item (held_item)
  );

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk    (clk),
    .rst    (rst),
    .step   (fire),
    .item   (held_item),
    .result (next_result)
  );

  tccw_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .load_result (next_result),
    .free        (drain),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

  assign cell_write   = out_result.cell_write;
  assign cell_address = out_result.cell_address;
  assign cell_char    = out_result.cell_char;
  assign cell_attr    = out_result.cell_attr;
  assign cursor_col   = out_result.cursor_col;
  assign cursor_row   = out_result.cursor_row;

  `TCCW_ASSERT(a_cursor_on_screen, !out_valid || ((32'(cursor_col) < COLUMNS) && (32'(cursor_row) < ROWS)), "cursor left the screen")
  `TCCW_ASSERT(a_idle_cell_zero, !out_valid || cell_write || ((cell_address == '0) && (cell_char == '0) && (cell_attr == '0)), "non-write result carries cell data")
  `TCCW_ASSERT(a_write_printable, !out_valid || !cell_write || (cell_char >= FIRST_PRINTABLE), "cell written with a control code")
  `TCCW_ASSERT_NEXT(a_fire_gives_result, fire, out_valid, "processed word produced no result")

endmodule

// ===== src/tccw_in_reg.sv =====
// Input register stage: holds one accepted word until the cursor logic takes it.
// Depends on tccw_pkg.
module tccw_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tccw_pkg::item_t in_item,
  input  logic            drain,
  output logic            fire,
  output tccw_pkg::item_t held_item
);
  import tccw_pkg::*;

  logic held_valid;

  assign fire     = held_valid && drain;
  assign in_ready = !held_valid || drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== src/tccw_cursor.sv =====
// Cursor state and the per-word cell/cursor update logic.
// Depends on tccw_pkg.
module tccw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tccw_pkg::item_t   item,
  output tccw_pkg::result_t result
);
  import tccw_pkg::*;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [COL_W:0]   COLS_X   = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W:0]   ROWS_X   = (ROW_W + 1)'(ROWS);
  localparam logic [ADDR_W:0]  COLS_A   = (ADDR_W + 1)'(COLUMNS);

  logic [COL_W-1:0] column_pos, column_pos_next;
  logic [ROW_W-1:0] row_pos, row_pos_next;

  logic [COL_W:0]   col_inc;
  logic [COL_W:0]   col_tab;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W-1:0] row_wrap;
  logic [ADDR_W:0]  addr_full;

  always_comb begin
    col_inc   = {1'b0, column_pos} + (COL_W + 1)'(1);
    col_tab   = ({1'b0, column_pos} + TAB_STEP) & TAB_ALIGN_MASK;
    row_inc   = {1'b0, row_pos} + (ROW_W + 1)'(1);
    row_wrap  = (row_inc >= ROWS_X) ? '0 : row_inc[ROW_W-1:0];
    addr_full = (ADDR_W + 1)'((ADDR_W + 1)'(row_pos) * COLS_A)
              + (ADDR_W + 1)'(column_pos);
  end

  always_comb begin
    column_pos_next     = column_pos;
    row_pos_next        = row_pos;
    result.cell_write   = 1'b0;
    result.cell_address = '0;
    result.cell_char    = '0;
    result.cell_attr    = '0;
    if (item.kind == KIND_SET) begin
      column_pos_next = (item.new_col >= COL_LAST) ? COL_LAST : item.new_col;
      row_pos_next    = (item.new_row >= ROW_LAST) ? ROW_LAST : item.new_row;
    end else if (item.char_code >= FIRST_PRINTABLE) begin
      result.cell_write   = 1'b1;
      result.cell_address = addr_full[ADDR_W-1:0];
      result.cell_char    = item.char_code;
      result.cell_attr    = item.color[6:0];
      if (col_inc >= COLS_X) begin
        column_pos_next = '0;
        row_pos_next    = row_wrap;
      end else begin
        column_pos_next = col_inc[COL_W-1:0];
      end
    end else begin
      case (item.char_code)
        CODE_NEWLINE: begin
          column_pos_next = '0;
          row_pos_next    = row_wrap;
        end
        CODE_RETURN: begin
          column_pos_next = '0;
        end
        CODE_TAB: begin
          // tab stop past the right edge wraps like a full line
          if (col_tab >= COLS_X) begin
            column_pos_next = '0;
            row_pos_next    = row_wrap;
          end else begin
            column_pos_next = col_tab[COL_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
    result.cursor_col = column_pos_next;
    result.cursor_row = row_pos_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (step) begin
      column_pos <= column_pos_next;
      row_pos    <= row_pos_next;
    end
  end

endmodule

// ===== src/tccw_out_reg.sv =====
// Result register: holds one result word until the consumer takes it.
// Depends on tccw_pkg.
module tccw_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tccw_pkg::result_t load_result,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output tccw_pkg::result_t out_result
);
  import tccw_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule

// ===== test/tccw_cell_checker.sv =====
// Checker for the text console cell writer: tracks the cursor, predicts the result
// word of every accepted input word and compares the returned words field by field.
// Depends on tccw_pkg.
module tccw_cell_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        kind,
  input  logic [7:0]                  char_code,
  input  logic [7:0]                  color,
  input  logic [tccw_pkg::COL_W-1:0]  new_col,
  input  logic [tccw_pkg::ROW_W-1:0]  new_row,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        cell_write,
  input  logic [tccw_pkg::ADDR_W-1:0] cell_address,
  input  logic [7:0]                  cell_char,
  input  logic [6:0]                  cell_attr,
  input  logic [tccw_pkg::COL_W-1:0]  cursor_col,
  input  logic [tccw_pkg::ROW_W-1:0]  cursor_row,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tccw_pkg::*;

  logic [COL_W-1:0] col_now;
  logic [ROW_W-1:0] row_now;
  result_t          cells_due[$];

  function automatic void line_feed();
    col_now = '0;
    if (int'(row_now) + 1 >= ROWS) row_now = '0;
    else row_now = row_now + ROW_W'(1);
  endfunction

  // Moves the cursor for one word and returns the result word it should give.
  function automatic result_t console_step(logic k, logic [7:0] code, logic [7:0] clr,
                                           logic [COL_W-1:0] ncol, logic [ROW_W-1:0] nrow);
    result_t r;
    int      c;
    r = '0;
    if (k == KIND_SET) begin
      col_now = (int'(ncol) >= COLUMNS) ? COL_W'(COLUMNS - 1) : ncol;
      row_now = (int'(nrow) >= ROWS) ? ROW_W'(ROWS - 1) : nrow;
    end else if (code >= FIRST_PRINTABLE) begin
      r.cell_write   = 1'b1;
      r.cell_address = ADDR_W'(int'(row_now) * COLUMNS + int'(col_now));
      r.cell_char    = code;
      r.cell_attr    = clr[6:0];
      c = int'(col_now) + 1;
      if (c >= COLUMNS) line_feed();
      else col_now = COL_W'(c);
    end else if (code == CODE_NEWLINE) begin
      line_feed();
    end else if (code == CODE_RETURN) begin
      col_now = '0;
    end else if (code == CODE_TAB) begin
      c = (int'(col_now) + int'(TAB_STEP)) / int'(TAB_STEP) * int'(TAB_STEP);
      if (c >= COLUMNS) line_feed();
      else col_now = COL_W'(c);
    end
    r.cursor_col = col_now;
    r.cursor_row = row_now;
    return r;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      col_now = '0;
      row_now = '0;
      cells_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (cells_due.size() == 0) begin
          $error("result word with no word outstanding");
          fail_count++;
        end else begin
          want = cells_due.pop_front();
          check_field("cell_write", 32'(want.cell_write), 32'(cell_write));
          check_field("cell_address", 32'(want.cell_address), 32'(cell_address));
          check_field("cell_char", 32'(want.cell_char), 32'(cell_char));
          check_field("cell_attr", 32'(want.cell_attr), 32'(cell_attr));
          check_field("cursor_col", 32'(want.cursor_col), 32'(cursor_col));
          check_field("cursor_row", 32'(want.cursor_row), 32'(cursor_row));
        end
      end
      if (in_valid && in_ready)
        cells_due.push_back(console_step(kind, char_code, color, new_col, new_row));
    end
    pending = cells_due.size();
  end

endmodule

// ===== test/tb.sv =====
// Top of the text console cell writer testbench: clock, reset, directed and random
// words, back-pressure, watchdog and verdict. Depends on tccw_pkg,
// text_console_cell_writer and tccw_cell_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tccw_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int QUIET_LIMIT = 1000;
  localparam int RX_HOLD     = 80;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic              kind      = KIND_PUT;
  logic [7:0]        char_code = '0;
  logic [7:0]        color     = '0;
  logic [COL_W-1:0]  new_col   = '0;
  logic [ROW_W-1:0]  new_row   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              cell_write;
  logic [ADDR_W-1:0] cell_address;
  logic [7:0]        cell_char;
  logic [6:0]        cell_attr;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;

  int fail_count;
  int pending;
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit rx_hold_req = 1'b0;

  text_console_cell_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (.*);

  tccw_cell_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end
      out_ready <= !rx_idle_on || ($urandom_range(99) >= 27);
    end
  end

  task automatic send_word(logic k, logic [7:0] code, logic [7:0] clr,
                           logic [COL_W-1:0] ncol, logic [ROW_W-1:0] nrow);
    while (tx_idle_on && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    char_code <= code;
    color     <= clr;
    new_col   <= ncol;
    new_row   <= nrow;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic put_char(logic [7:0] code, logic [7:0] clr);
    send_word(KIND_PUT, code, clr, COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)));
  endtask

  task automatic set_cursor(logic [COL_W-1:0] ncol, logic [ROW_W-1:0] nrow);
    send_word(KIND_SET, 8'($urandom_range(255)), 8'($urandom_range(255)), ncol, nrow);
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10)
      set_cursor(COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)));
    else if (pick < 62)
      put_char(8'($urandom_range(255, 32)), 8'($urandom_range(255)));
    else if (pick < 72)
      put_char(CODE_NEWLINE, 8'($urandom_range(255)));
    else if (pick < 82)
      put_char(CODE_TAB, 8'($urandom_range(255)));
    else if (pick < 88)
      put_char(CODE_RETURN, 8'($urandom_range(255)));
    else
      put_char(8'($urandom_range(31)), 8'($urandom_range(255)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed words
    put_char(8'h41, 8'hFF);            // attribute top bit dropped
    put_char(FIRST_PRINTABLE, 8'h00);
    put_char(8'hFF, 8'h80);
    put_char(8'h80, 8'h7F);
    put_char(8'h00, 8'hFF);            // NUL ignored
    put_char(8'h1F, 8'h55);            // other control ignored
    put_char(CODE_TAB, 8'hAA);
    put_char(CODE_RETURN, 8'h01);
    put_char(CODE_NEWLINE, 8'h02);
    set_cursor(7'd127, 5'd31);         // saturates to last cell
    put_char(8'h7E, 8'h1E);            // last cell wraps to the origin
    set_cursor(7'd76, 5'd24);
    put_char(CODE_TAB, 8'h00);         // tab past last column on last row
    set_cursor(7'd78, 5'd3);
    put_char(CODE_TAB, 8'h00);
    set_cursor(7'd80, 5'd25);
    put_char(CODE_NEWLINE, 8'h00);     // newline on last row wraps
    set_cursor(7'd79, 5'd0);
    put_char(8'h5A, 8'hC3);
    set_cursor(7'd5, 5'd10);
    put_char(CODE_TAB, 8'h00);
    put_char(CODE_RETURN, 8'h00);
    set_cursor(7'd0, 5'd0);

    repeat (200) random_word();
    rx_hold_req = 1'b1;                // sender keeps offering while results back up
    repeat (200) random_word();
    drain();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (100) random_word();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (150) random_word();
    drain();
    repeat (6) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      if (pending != 0) $error("%0d result words never arrived", pending);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/tccw_pkg.sv
src/tccw_in_reg.sv
src/tccw_cursor.sv
src/tccw_out_reg.sv
src/text_console_cell_writer.sv
test/tccw_cell_checker.sv
test/tb.sv
